// ===== rtl/crz_pkg.sv =====
// Shared constants, types and lookup functions for the ternary crazy-op pipeline.
// No dependencies; used by the interfaces, crz_stage and ternary_crazy_op.
package crz_pkg;

	localparam int TRIT_COUNT  = 10;
	localparam int WORD_W      = 16;
	// each stage peels two trits (one base-9 digit)
	localparam int STAGE_COUNT = (TRIT_COUNT + 1) / 2;

	// floor(x / 9) == (x * DIV9_MUL) >> DIV9_SHIFT, exact for any 16-bit x
	localparam logic [WORD_W-1:0] DIV9_MUL   = 16'd58255;
	localparam int                DIV9_SHIFT = 19;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [1:0]        trit_t;
	typedef logic [3:0]        digit9_t;

	typedef struct packed {
		word_t   acc;
		word_t   mem;
		word_t   sum;
		digit9_t pend;
	} crz_lane_t;

	// result trit, indexed by memory trit and accumulator trit
	function automatic trit_t crz_trit(input trit_t tm, input trit_t ta);
		trit_t t;
		case ({tm, ta})
			4'b00_00: t = 2'd1;
			4'b00_01: t = 2'd0;
			4'b00_10: t = 2'd0;
			4'b01_00: t = 2'd1;
			4'b01_01: t = 2'd0;
			4'b01_10: t = 2'd2;
			4'b10_00: t = 2'd2;
			4'b10_01: t = 2'd2;
			4'b10_10: t = 2'd1;
			default:  t = 2'd0;
		endcase
		return t;
	endfunction

	// split a base-9 digit into {high trit, low trit}
	function automatic logic [3:0] split9(input digit9_t r);
		logic [3:0] hl;
		case (r)
			4'd0:    hl = {2'd0, 2'd0};
			4'd1:    hl = {2'd0, 2'd1};
			4'd2:    hl = {2'd0, 2'd2};
			4'd3:    hl = {2'd1, 2'd0};
			4'd4:    hl = {2'd1, 2'd1};
			4'd5:    hl = {2'd1, 2'd2};
			4'd6:    hl = {2'd2, 2'd0};
			4'd7:    hl = {2'd2, 2'd1};
			4'd8:    hl = {2'd2, 2'd2};
			default: hl = {2'd0, 2'd0};
		endcase
		return hl;
	endfunction

	// 9**k modulo 2**WORD_W
	function automatic word_t pow9(input int k);
		word_t p;
		p = word_t'(1);
		for (int i = 0; i < k; i++) begin
			p = word_t'(p * word_t'(9));
		end
		return p;
	endfunction

	// largest value the result can take
	function automatic word_t result_max();
		longint p;
		p = 1;
		for (int i = 0; i < TRIT_COUNT; i++) begin
			if (p <= 65536) begin
				p = p * 3;
			end
		end
		if (p > 65536) begin
			p = 65536;
		end
		return word_t'(p - 1);
	endfunction

	localparam word_t RESULT_MAX = result_max();

endpackage

// ===== rtl/crz_if.sv =====
// Valid/ready channel interfaces for operand pairs and results.
// Depends on crz_pkg for the word width.
interface crz_in_if import crz_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t acc_word;
	word_t mem_word;

	modport source(output valid, output acc_word, output mem_word, input ready);
	modport sink(input valid, input acc_word, input mem_word, output ready);
endinterface

interface crz_out_if import crz_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t result_word;

	modport source(output valid, output result_word, input ready);
	modport sink(input valid, input result_word, output ready);
endinterface

// ===== rtl/crz_stage.sv =====
// One pipeline stage: divide both operands by nine, map the two trit pairs
// through the crazy table, and fold in the previous stage's digit. Uses crz_pkg.
module crz_stage import crz_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      hi_en,
	input  word_t     pend_weight,
	input  logic      vld_in,
	input  crz_lane_t lane_in,
	output logic      vld,
	output crz_lane_t lane
);

	logic [2*WORD_W-1:0] prod_a, prod_m;
	word_t               q_a, q_m, r_a, r_m;
	logic [3:0]          hl_a, hl_m;
	trit_t               d_lo, d_hi;
	digit9_t             pair;
	word_t               fold;
	crz_lane_t           nxt;
	logic                vld_s1;
	crz_lane_t           lane_s1;

	assign prod_a = (2*WORD_W)'(lane_in.acc) * (2*WORD_W)'(DIV9_MUL);
	assign prod_m = (2*WORD_W)'(lane_in.mem) * (2*WORD_W)'(DIV9_MUL);
	assign q_a    = WORD_W'(prod_a >> DIV9_SHIFT);
	assign q_m    = WORD_W'(prod_m >> DIV9_SHIFT);
	assign r_a    = lane_in.acc - ((q_a << 3) + q_a);
	assign r_m    = lane_in.mem - ((q_m << 3) + q_m);
	assign hl_a   = split9(r_a[3:0]);
	assign hl_m   = split9(r_m[3:0]);
	assign d_lo   = crz_trit(hl_m[1:0], hl_a[1:0]);
	// drop the upper trit when the word has an odd trit count
	assign d_hi   = hi_en ? crz_trit(hl_m[3:2], hl_a[3:2]) : 2'd0;
	assign pair   = digit9_t'(d_lo) + digit9_t'({d_hi, 1'b0}) + digit9_t'(d_hi);
	assign fold   = WORD_W'(word_t'(lane_in.pend) * pend_weight);

	always_comb begin
		nxt.acc  = q_a;
		nxt.mem  = q_m;
		nxt.sum  = lane_in.sum + fold;
		nxt.pend = pair;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lane_s1 <= nxt;
		end
	end

	assign vld  = vld_s1;
	assign lane = lane_s1;

endmodule

// ===== rtl/ternary_crazy_op.sv =====
// Top level of the ternary crazy-op pipeline: input channel, divide stages, output register.
// Depends on crz_pkg, crz_in_if / crz_out_if and crz_stage.
//
// Takes an operand pair (acc_word, mem_word), each read as TRIT_COUNT base-3 digits,
// and returns result_word whose trits come from the crazy table indexed by memory
// and accumulator trit. One item is accepted every cycle unless a result held by the
// sink stalls the whole pipeline; each result passes through one registered stage per
// divide-by-nine step on both operands, then the final add into the output register.
// Nothing is dropped or repeated. No state is kept between items and no configuration.
module ternary_crazy_op import crz_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	crz_in_if.sink     operand,
	crz_out_if.source  result
);

	logic      en;
	logic      vld  [STAGE_COUNT+1];
	crz_lane_t lane [STAGE_COUNT+1];
	word_t     last_fold;
	logic      rvld_s1;
	word_t     result_s1;

	// advance everything whenever the output register is free or being drained
	assign en            = !rvld_s1 || result.ready;
	assign operand.ready = en;

	assign vld[0]       = operand.valid;
	assign lane[0].acc  = operand.acc_word;
	assign lane[0].mem  = operand.mem_word;
	assign lane[0].sum  = '0;
	assign lane[0].pend = '0;

	for (genvar k = 0; k < STAGE_COUNT; k++) begin : g_stage
		crz_stage u_stage (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.hi_en      ((2*k + 1) < TRIT_COUNT),
			.pend_weight((k == 0) ? word_t'(0) : pow9(k - 1)),
			.vld_in     (vld[k]),
			.lane_in    (lane[k]),
			.vld        (vld[k+1]),
			.lane       (lane[k+1])
		);
	end

	assign last_fold = WORD_W'(word_t'(lane[STAGE_COUNT].pend) * pow9(STAGE_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s1 <= 1'b0;
		end else if (en) begin
			rvld_s1 <= vld[STAGE_COUNT];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_s1 <= lane[STAGE_COUNT].sum + last_fold;
		end
	end

	assign result.valid       = rvld_s1;
	assign result.result_word = result_s1;

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		rvld_s1 |-> result_s1 <= RESULT_MAX)
		else $error("result word out of range");

	a_enter_first: assert property (@(posedge clk) disable iff (!arst_n)
		operand.valid && operand.ready |=> vld[1])
		else $error("accepted item missing from first stage");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld[1]) && $stable(vld[STAGE_COUNT]) && $stable(rvld_s1))
		else $error("pipeline moved during stall");

	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		rvld_s1 && !result.ready |-> !operand.ready)
		else $error("input taken while output blocked");

	a_drain_last: assert property (@(posedge clk) disable iff (!arst_n)
		vld[STAGE_COUNT] && en |=> rvld_s1)
		else $error("last stage item lost before output register");

endmodule

// ===== sim/tb_ternary_crazy_op.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ternary_crazy_op: corner pairs, then random operand pairs.
// Depends on crz_pkg, crz_in_if / crz_out_if and the ternary_crazy_op RTL.
module tb_ternary_crazy_op;
	import crz_pkg::*;

	localparam int RANDOM_ITEMS  = 1700;
	localparam int CORNER_ROWS   = 18;
	localparam int MAX_GAP       = 11;
	localparam int LONG_HOLD     = 300;
	localparam int HOLD_AT       = 450;
	localparam int DRAIN_AT      = 900;
	localparam int TAIL_CYCLES   = 20;
	localparam int CYCLE_LIMIT   = 400000;
	localparam word_t ALL_ONES   = 16'd29524;
	localparam word_t ALL_TWOS   = 16'd59048;
	localparam word_t TRIT_WRAP  = 16'd59049;

	typedef struct packed {
		word_t acc;
		word_t mem;
		logic  typed;
		word_t want;
	} pair_row_t;

	logic clk;
	logic arst_n;

	crz_in_if  operand_ch ();
	crz_out_if result_ch ();

	ternary_crazy_op uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (operand_ch),
		.result  (result_ch)
	);

	// row = memory trit, column = accumulator trit
	int crazy_tbl [3][3] = '{'{1, 0, 0}, '{1, 0, 2}, '{2, 2, 1}};

	// typed-in results follow from all-equal trit words
	pair_row_t corner_pairs [CORNER_ROWS] = '{
		'{16'd0,     16'd0,     1'b1, ALL_ONES},
		'{ALL_TWOS,  ALL_TWOS,  1'b1, ALL_ONES},
		'{ALL_TWOS,  16'd0,     1'b1, 16'd0},
		'{16'd0,     ALL_TWOS,  1'b1, ALL_TWOS},
		'{ALL_TWOS,  ALL_ONES,  1'b1, ALL_TWOS},
		'{ALL_ONES,  16'd0,     1'b1, 16'd0},
		'{ALL_ONES,  ALL_ONES,  1'b1, 16'd0},
		'{16'd0,     ALL_ONES,  1'b1, ALL_ONES},
		'{ALL_ONES,  ALL_TWOS,  1'b1, ALL_TWOS},
		'{TRIT_WRAP, 16'd0,     1'b1, ALL_ONES},
		'{TRIT_WRAP, TRIT_WRAP, 1'b1, ALL_ONES},
		'{16'hFFFF,  16'hFFFF,  1'b0, 16'd0},
		'{16'hFFFF,  16'd0,     1'b0, 16'd0},
		'{16'd0,     16'hFFFF,  1'b0, 16'd0},
		'{16'h5555,  16'hAAAA,  1'b0, 16'd0},
		'{16'hAAAA,  16'h5555,  1'b0, 16'd0},
		'{16'd1,     16'd2,     1'b0, 16'd0},
		'{16'd12345, 16'd54321, 1'b0, 16'd0}
	};

	word_t pending_results [$];
	logic  cur_typed;
	word_t cur_want;
	int    error_count = 0;
	int    cycle_count = 0;

	function automatic word_t crz_predict(input word_t acc, input word_t mem);
		longint unsigned a;
		longint unsigned m;
		longint unsigned sum;
		longint unsigned weight;
		a = acc;
		m = mem;
		sum = 0;
		weight = 1;
		for (int i = 0; i < TRIT_COUNT; i++) begin
			sum += longint'(crazy_tbl[m % 3][a % 3]) * weight;
			a /= 3;
			m /= 3;
			weight *= 3;
		end
		return word_t'(sum);
	endfunction

	function automatic int draw_gap(input bit quiet);
		if (quiet) begin
			return 0;
		end
		return $urandom_range(0, MAX_GAP);
	endfunction

	function automatic word_t make_operand();
		longint unsigned v;
		longint unsigned weight;
		int              fill;
		v = 0;
		weight = 1;
		case ($urandom_range(0, 9))
			0: v = $urandom_range(0, 65535);
			1: v = $urandom_range(59040, 59058);
			2: v = $urandom_range(65520, 65535);
			3: v = $urandom_range(0, 20);
			4: begin
				// mostly one repeated trit, a few strays
				fill = $urandom_range(0, 2);
				for (int i = 0; i < TRIT_COUNT; i++) begin
					if ($urandom_range(0, 3) == 0) begin
						v += $urandom_range(0, 2) * weight;
					end else begin
						v += fill * weight;
					end
					weight *= 3;
				end
			end
			default: v = $urandom_range(0, 59048);
		endcase
		return word_t'(v);
	endfunction

	task automatic send_pair(input word_t acc, input word_t mem, input logic typed,
			input word_t want, input int gap);
		operand_ch.valid    <= 1'b1;
		operand_ch.acc_word <= acc;
		operand_ch.mem_word <= mem;
		cur_typed           <= typed;
		cur_want            <= want;
		@(posedge clk);
		while (!operand_ch.ready) begin
			@(posedge clk);
		end
		if (gap > 0) begin
			operand_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_ternary_crazy_op NOT OK");
			$finish;
		end
	end

	// record each accepted item, then check each delivered result
	always @(posedge clk) begin
		if (arst_n && operand_ch.valid && operand_ch.ready) begin
			if (cur_typed) begin
				pending_results.push_back(cur_want);
			end else begin
				pending_results.push_back(crz_predict(operand_ch.acc_word, operand_ch.mem_word));
			end
		end
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result_word: expected none, actual %0d", result_ch.result_word);
				error_count++;
			end else if (result_ch.result_word !== pending_results[0]) begin
				$error("result_word: expected %0d, actual %0d",
					pending_results[0], result_ch.result_word);
				error_count++;
				void'(pending_results.pop_front());
			end else begin
				void'(pending_results.pop_front());
			end
		end
	end

	initial begin : result_sink
		int stall;
		int taken;
		taken = 0;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// hold off long once so the pipeline fills and stalls its input
			if (taken == HOLD_AT) begin
				stall = LONG_HOLD;
			end else begin
				stall = draw_gap((taken % 250) < 50);
			end
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid) begin
				@(posedge clk);
			end
			taken++;
		end
	end

	initial begin : operand_source
		word_t acc;
		word_t mem;
		bit    quiet;
		arst_n              <= 1'b0;
		operand_ch.valid    <= 1'b0;
		operand_ch.acc_word <= '0;
		operand_ch.mem_word <= '0;
		cur_typed           <= 1'b0;
		cur_want            <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < CORNER_ROWS; r++) begin
			send_pair(corner_pairs[r].acc, corner_pairs[r].mem, corner_pairs[r].typed,
				corner_pairs[r].want, draw_gap(r < 6));
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			acc = make_operand();
			mem = make_operand();
			// keep offering items back to back in periodic bursts and while the sink holds off
			quiet = ((n % 200) < 40) || (n > HOLD_AT - 20 && n < HOLD_AT + 300);
			send_pair(acc, mem, 1'b0, '0, draw_gap(quiet));
			if (n == DRAIN_AT) begin
				// drop valid and wait for the pipeline to empty
				operand_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0) begin
					@(posedge clk);
				end
			end
		end
		operand_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("tb_ternary_crazy_op OK");
		end else begin
			$display("tb_ternary_crazy_op NOT OK");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/crz_pkg.sv
rtl/crz_if.sv
rtl/crz_stage.sv
rtl/ternary_crazy_op.sv
sim/tb_ternary_crazy_op.sv
